[hw/rtl/lsdf_pkg.sv]
// lsdf_pkg: shared types, widths and constants of the spring-damper force pipeline
// no dependencies; imported by every module under hw/rtl
`timescale 1ns / 1ps

package lsdf_pkg;

    localparam int FRAC_BITS  = 16;

    localparam int POS_W      = 32;
    localparam int PAR_W      = 31;
    localparam int SQ_W       = 2 * POS_W;
    localparam int LEN_W      = POS_W;
    localparam int SQ_STAGES  = LEN_W;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int UW         = FRAC_BITS + 1;
    localparam int PW         = POS_W + 1;
    localparam int DOTW       = PW + 2;
    localparam int EW         = LEN_W + 2;
    localparam int AW         = PAR_W + (EW - 1) - FRAC_BITS;
    localparam int BW         = PAR_W + (DOTW - 1) - FRAC_BITS;
    localparam int GW         = BW + 2;
    localparam int TAIL_STAGES = 6;
    localparam int PIPE_DEPTH = 3 + SQ_STAGES + DIV_STAGES + TAIL_STAGES;
    localparam int CFG_IW     = 3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ANCHOR_X  = 3'd0,
        CFG_ANCHOR_Y  = 3'd1,
        CFG_ANCHOR_Z  = 3'd2,
        CFG_STIFFNESS = 3'd3,
        CFG_DAMPING   = 3'd4,
        CFG_REST_LEN  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] attach_x;
        logic signed [POS_W-1:0] attach_y;
        logic signed [POS_W-1:0] attach_z;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic signed [POS_W-1:0] vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] force_x;
        logic signed [POS_W-1:0] force_y;
        logic signed [POS_W-1:0] force_z;
        logic [PAR_W-1:0]        spring_length;
        logic                    saturated;
    } out_item_t;

    // per-item data that rides alongside the root and divide units
    typedef struct packed {
        logic [2:0][POS_W-1:0] dmag;
        logic [2:0]            dneg;
        logic [2:0][POS_W-1:0] vmag;
        logic [2:0]            vneg;
        logic                  sat;
    } side_t;

    // data carried through the product stages
    typedef struct packed {
        logic [2:0][UW-1:0] umag;
        logic [2:0]         uneg;
        logic [LEN_W-1:0]   len;
        logic               sat;
    } tail_t;

    function automatic logic [POS_W-1:0] mag32(input logic signed [POS_W-1:0] a);
        return a[POS_W-1] ? (~a) + POS_W'(1) : a;
    endfunction

endpackage

[hw/rtl/linear_spring_damper_force.sv]
// linear_spring_damper_force: Q16.16, PIPE_DEPTH stages: difference, squares,
// sum, 32 root stages, one divider stage per quotient bit, then six product and clip
// stages; throughput one item per cycle.
// A stall at the output holds the whole pipeline in place.
// Reset (rst_n, asynchronous) clears the valid bits and all configuration registers.
// depends on lsdf_pkg, lsdf_sqrt, lsdf_div
`timescale 1ns / 1ps

module linear_spring_damper_force (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lsdf_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lsdf_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lsdf_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [lsdf_pkg::POS_W-1:0]    cfg_data
);
    import lsdf_pkg::*;

    localparam int DIV_OUT = 3 + SQ_STAGES + DIV_STAGES - 1;

    // configuration
    logic [2:0][POS_W-1:0] anchor_reg;
    logic [PAR_W-1:0]      stiff_reg;
    logic [PAR_W-1:0]      damp_reg;
    logic [PAR_W-1:0]      rest_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg <= '0;
            stiff_reg  <= '0;
            damp_reg   <= '0;
            rest_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ANCHOR_X:  anchor_reg[0] <= cfg_data;
                CFG_ANCHOR_Y:  anchor_reg[1] <= cfg_data;
                CFG_ANCHOR_Z:  anchor_reg[2] <= cfg_data;
                CFG_STIFFNESS: stiff_reg     <= cfg_data[PAR_W-1:0];
                CFG_DAMPING:   damp_reg      <= cfg_data[PAR_W-1:0];
                CFG_REST_LEN:  rest_reg      <= cfg_data[PAR_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign en        = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // stage 1: difference to anchor, clipped
    logic [2:0][POS_W-1:0] att;
    logic [2:0][POS_W-1:0] vel;
    side_t                 s1_next;
    side_t                 s1_reg;

    assign att = {in_data.attach_z, in_data.attach_y, in_data.attach_x};
    assign vel = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

    always_comb
    begin
        logic signed [POS_W:0]   diff;
        logic signed [POS_W-1:0] dclip;
        s1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff = $signed({att[i][POS_W-1], att[i]})
                 - $signed({anchor_reg[i][POS_W-1], anchor_reg[i]});
            if (diff > $signed({2'b00, {(POS_W-1){1'b1}}}))
            begin
                dclip = {1'b0, {(POS_W-1){1'b1}}};
                s1_next.sat = 1'b1;
            end
            else if (diff < $signed({2'b11, {(POS_W-1){1'b0}}}))
            begin
                dclip = {1'b1, {(POS_W-1){1'b0}}};
                s1_next.sat = 1'b1;
            end
            else
                dclip = diff[POS_W-1:0];
            s1_next.dmag[i] = mag32(dclip);
            s1_next.dneg[i] = dclip[POS_W-1];
            s1_next.vmag[i] = mag32(vel[i]);
            s1_next.vneg[i] = vel[i][POS_W-1];
        end
    end

    // stage 2: squares; stage 3: sum
    logic [2:0][SQ_W-1:0] s2_sq_next;
    logic [2:0][SQ_W-1:0] s2_sq_reg;
    side_t                s2_reg;
    logic [SQ_W-1:0]      s3_sum_next;
    logic [SQ_W-1:0]      s3_sum_reg;
    side_t                s3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s2_sq_next[i] = SQ_W'(s1_reg.dmag[i]) * SQ_W'(s1_reg.dmag[i]);
    end

    assign s3_sum_next = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_sq_reg  <= s2_sq_next;
            s2_reg     <= s1_reg;
            s3_sum_reg <= s3_sum_next;
            s3_reg     <= s2_reg;
        end
    end

    // length
    logic [LEN_W-1:0] root;
    side_t            sqline_reg [SQ_STAGES];

    lsdf_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (s3_sum_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqline_reg[0] <= s3_reg;
            for (int k = 1; k < SQ_STAGES; k++)
                sqline_reg[k] <= sqline_reg[k-1];
        end
    end

    // unit direction
    logic [2:0][UW-1:0] quo;
    side_t              divline_reg [DIV_STAGES];
    logic [LEN_W-1:0]   lenline_reg [DIV_STAGES];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        lsdf_div u_div (
            .clk  (clk),
            .en   (en),
            .dmag (sqline_reg[SQ_STAGES-1].dmag[i]),
            .len  (root),
            .quo  (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            divline_reg[0] <= sqline_reg[SQ_STAGES-1];
            lenline_reg[0] <= root;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                divline_reg[k] <= divline_reg[k-1];
                lenline_reg[k] <= lenline_reg[k-1];
            end
        end
    end

    // stage a: u.v products and length error
    side_t              sa_side;
    tail_t              ta_next;
    tail_t              ta_reg;
    logic [2:0][PW-1:0] pa_mag_next;
    logic [2:0][PW-1:0] pa_mag_reg;
    logic [2:0]         pa_neg_next;
    logic [2:0]         pa_neg_reg;
    logic [EW-2:0]      ea_mag_next;
    logic [EW-2:0]      ea_mag_reg;
    logic               ea_neg_next;
    logic               ea_neg_reg;

    assign sa_side = divline_reg[DIV_STAGES-1];

    always_comb
    begin
        logic [UW+POS_W-1:0]  prod;
        logic signed [EW-1:0] err;
        ta_next.len = lenline_reg[DIV_STAGES-1];
        ta_next.sat = sa_side.sat;
        for (int i = 0; i < 3; i++)
        begin
            // zero length gives a zero direction
            ta_next.umag[i] = (ta_next.len == '0) ? '0 : quo[i];
            ta_next.uneg[i] = sa_side.dneg[i];
            prod = (UW+POS_W)'(ta_next.umag[i]) * (UW+POS_W)'(sa_side.vmag[i]);
            pa_mag_next[i] = PW'(prod >> FRAC_BITS);
            pa_neg_next[i] = sa_side.dneg[i] ^ sa_side.vneg[i];
        end
        err = $signed(EW'(ta_next.len)) - $signed(EW'(rest_reg));
        ea_neg_next = err[EW-1];
        ea_mag_next = err[EW-1] ? (EW-1)'(-err) : err[EW-2:0];
    end

    // stage b: dot product and stiffness term
    tail_t           tb_reg;
    logic [DOTW-2:0] dot_mag_next;
    logic [DOTW-2:0] dot_mag_reg;
    logic            dot_neg_next;
    logic            dot_neg_reg;
    logic [AW-1:0]   a_mag_next;
    logic [AW-1:0]   a_mag_reg;
    logic            a_neg_reg;

    always_comb
    begin
        logic signed [DOTW-1:0]    dot;
        logic signed [DOTW-1:0]    term;
        logic [PAR_W+EW-2:0]       aprod;
        dot = '0;
        for (int i = 0; i < 3; i++)
        begin
            term = $signed(DOTW'(pa_mag_reg[i]));
            dot  = dot + (pa_neg_reg[i] ? -term : term);
        end
        dot_neg_next = dot[DOTW-1];
        dot_mag_next = dot[DOTW-1] ? (DOTW-1)'(-dot) : dot[DOTW-2:0];
        aprod = (PAR_W+EW-1)'(stiff_reg) * (PAR_W+EW-1)'(ea_mag_reg);
        a_mag_next = AW'(aprod >> FRAC_BITS);
    end

    // stage c: damping term
    tail_t                 tc_reg;
    logic [AW-1:0]         ac_mag_reg;
    logic                  ac_neg_reg;
    logic [BW-1:0]         b_mag_next;
    logic [BW-1:0]         b_mag_reg;
    logic                  b_neg_reg;
    logic [PAR_W+DOTW-2:0] bprod;

    assign bprod      = (PAR_W+DOTW-1)'(damp_reg) * (PAR_W+DOTW-1)'(dot_mag_reg);
    assign b_mag_next = BW'(bprod >> FRAC_BITS);

    // stage d: scalar g = -(a + b)
    tail_t         td_reg;
    logic [GW-2:0] g_mag_next;
    logic [GW-2:0] g_mag_reg;
    logic          g_neg_next;
    logic          g_neg_reg;

    always_comb
    begin
        logic signed [GW-1:0] sa;
        logic signed [GW-1:0] sb;
        logic signed [GW-1:0] g;
        sa = $signed(GW'(ac_mag_reg));
        sb = $signed(GW'(b_mag_reg));
        g  = -((ac_neg_reg ? -sa : sa) + (b_neg_reg ? -sb : sb));
        g_neg_next = g[GW-1];
        g_mag_next = g[GW-1] ? (GW-1)'(-g) : g[GW-2:0];
    end

    // stage e: force components
    tail_t              te_reg;
    logic [2:0][GW-1:0] f_mag_next;
    logic [2:0][GW-1:0] f_mag_reg;
    logic [2:0]         f_neg_next;
    logic [2:0]         f_neg_reg;

    always_comb
    begin
        logic [GW+FRAC_BITS-1:0] fprod;
        for (int i = 0; i < 3; i++)
        begin
            fprod = (GW+FRAC_BITS)'(g_mag_reg) * (GW+FRAC_BITS)'(td_reg.umag[i]);
            f_mag_next[i] = GW'(fprod >> FRAC_BITS);
            f_neg_next[i] = g_neg_reg ^ td_reg.uneg[i];
        end
    end

    // stage f: clip into the output register
    out_item_t out_next;
    out_item_t out_reg;

    always_comb
    begin
        logic [2:0][POS_W-1:0] fo;
        logic                  sat;
        sat = te_reg.sat;
        for (int i = 0; i < 3; i++)
        begin
            if (f_neg_reg[i])
            begin
                if (f_mag_reg[i] > GW'({1'b1, {(POS_W-1){1'b0}}}))
                begin
                    fo[i] = {1'b1, {(POS_W-1){1'b0}}};
                    sat   = 1'b1;
                end
                else
                    fo[i] = -f_mag_reg[i][POS_W-1:0];
            end
            else if (f_mag_reg[i] > GW'({1'b0, {(POS_W-1){1'b1}}}))
            begin
                fo[i] = {1'b0, {(POS_W-1){1'b1}}};
                sat   = 1'b1;
            end
            else
                fo[i] = f_mag_reg[i][POS_W-1:0];
        end
        out_next.force_x = fo[0];
        out_next.force_y = fo[1];
        out_next.force_z = fo[2];
        // long spring: length clips, forces keep the full length
        if (te_reg.len[LEN_W-1])
        begin
            out_next.spring_length = '1;
            sat = 1'b1;
        end
        else
            out_next.spring_length = te_reg.len[PAR_W-1:0];
        out_next.saturated = sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg      <= ta_next;
            pa_mag_reg  <= pa_mag_next;
            pa_neg_reg  <= pa_neg_next;
            ea_mag_reg  <= ea_mag_next;
            ea_neg_reg  <= ea_neg_next;
            tb_reg      <= ta_reg;
            dot_mag_reg <= dot_mag_next;
            dot_neg_reg <= dot_neg_next;
            a_mag_reg   <= a_mag_next;
            a_neg_reg   <= ea_neg_reg;
            tc_reg      <= tb_reg;
            ac_mag_reg  <= a_mag_reg;
            ac_neg_reg  <= a_neg_reg;
            b_mag_reg   <= b_mag_next;
            b_neg_reg   <= dot_neg_reg;
            td_reg      <= tc_reg;
            g_mag_reg   <= g_mag_next;
            g_neg_reg   <= g_neg_next;
            te_reg      <= td_reg;
            f_mag_reg   <= f_mag_next;
            f_neg_reg   <= f_neg_next;
            out_reg     <= out_next;
        end
    end

    assign out_data = out_reg;

`ifndef NO_ASSERTIONS
    // a held pipeline keeps every valid bit where it is
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("valid bits moved during a stall");

    // the direction never exceeds one once the length is nonzero
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_OUT] && lenline_reg[DIV_STAGES-1] != '0 |->
            quo[0] <= UW'(1) << FRAC_BITS && quo[1] <= UW'(1) << FRAC_BITS
            && quo[2] <= UW'(1) << FRAC_BITS)
        else $error("unit vector component out of range");

    // zero length gives zero force
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.spring_length == '0 |->
            out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
        else $error("nonzero force at zero length");
`endif

endmodule

[hw/rtl/lsdf_sqrt.sv]
// lsdf_sqrt: pipelined integer square root, one result bit per stage
// depends on lsdf_pkg
`timescale 1ns / 1ps

module lsdf_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [lsdf_pkg::SQ_W-1:0]   radicand,
    output logic [lsdf_pkg::LEN_W-1:0]  root
);
    import lsdf_pkg::*;

    logic [SQ_W-1:0]  rem_reg  [SQ_STAGES];
    logic [LEN_W-1:0] root_reg [SQ_STAGES];

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_stage
        localparam int B = SQ_STAGES - 1 - j;
        logic [SQ_W-1:0]  rem_in;
        logic [LEN_W-1:0] root_in;
        logic [SQ_W+1:0]  trial;
        logic             fits;
        logic [SQ_W-1:0]  rem_next;
        logic [LEN_W-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign trial     = ((SQ_W+2)'(root_in) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
        assign fits      = {2'b00, rem_in} >= trial;
        assign rem_next  = fits ? rem_in - trial[SQ_W-1:0] : rem_in;
        assign root_next = fits ? root_in | (LEN_W'(1) << B) : root_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

[hw/rtl/lsdf_div.sv]
// lsdf_div: pipelined restoring divider, (dmag << FRAC_BITS) / len, one quotient bit per stage
// depends on lsdf_pkg
`timescale 1ns / 1ps

module lsdf_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [lsdf_pkg::POS_W-1:0]  dmag,
    input  logic [lsdf_pkg::LEN_W-1:0]  len,
    output logic [lsdf_pkg::UW-1:0]     quo
);
    import lsdf_pkg::*;

    localparam int RW = POS_W + FRAC_BITS;

    logic [RW-1:0]    rem_reg [DIV_STAGES];
    logic [LEN_W-1:0] den_reg [DIV_STAGES];
    logic [UW-1:0]    quo_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int K = DIV_STAGES - 1 - j;
        logic [RW-1:0]    rem_in;
        logic [LEN_W-1:0] den_in;
        logic [UW-1:0]    quo_in;
        logic [RW:0]      trial;
        logic             fits;
        logic [RW-1:0]    rem_next;
        logic [UW-1:0]    quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = RW'(dmag) << FRAC_BITS;
            assign den_in = len;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign trial    = (RW+1)'(den_in) << K;
        assign fits     = {1'b0, rem_in} >= trial;
        assign rem_next = fits ? rem_in - trial[RW-1:0] : rem_in;
        assign quo_next = fits ? quo_in | (UW'(1) << K) : quo_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

[tb/tb_linear_spring_damper_force.sv]
// tb_linear_spring_damper_force: self-checking bench for the spring-damper force pipeline
// a scoreboard class predicts each result from the accepted item; depends on lsdf_pkg and the rtl
`timescale 1ns / 1ps

module tb_linear_spring_damper_force;
    import lsdf_pkg::*;

    localparam int CLK_HALF   = 1;
    localparam int LAT_WAIT   = PIPE_DEPTH + 12;
    localparam int CYCLE_CAP  = 2000000;
    localparam int HOLD_LEN   = 400;
    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

    class force_scoreboard;
        longint    anc [3];
        longint    stiff, damp, rest;
        out_item_t pending_q [$];
        int        mismatches;

        function new();
            for (int i = 0; i < 3; i++) anc[i] = 0;
            stiff = 0; damp = 0; rest = 0; mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [POS_W-1:0] val);
            case (idx)
                CFG_ANCHOR_X:  anc[0] = longint'($signed(val));
                CFG_ANCHOR_Y:  anc[1] = longint'($signed(val));
                CFG_ANCHOR_Z:  anc[2] = longint'($signed(val));
                CFG_STIFFNESS: stiff = longint'({33'd0, val[PAR_W-1:0]});
                CFG_DAMPING:   damp  = longint'({33'd0, val[PAR_W-1:0]});
                CFG_REST_LEN:  rest  = longint'({33'd0, val[PAR_W-1:0]});
                default: ;
            endcase
        endfunction

        function bit [63:0] mag(longint a);
            return a < 0 ? 64'(-a) : 64'(a);
        endfunction

        function longint clip32(longint v, inout bit flag);
            if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
            return v;
        endfunction

        // truncated fixed-point product, magnitude clamped at 2^61
        function longint mul_q(longint a, longint b);
            bit         neg;
            bit [127:0] r;
            neg = (a < 0) != (b < 0);
            r = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> FRAC_BITS;
            if (r > (128'd1 << 61)) r = 128'd1 << 61;
            return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
        endfunction

        function bit [63:0] root_floor(bit [63:0] x);
            bit [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_input(in_item_t it);
            longint    d [3], v [3], u [3], f [3];
            longint    dot, g;
            bit [63:0] sq, len, q;
            bit        sat;
            out_item_t e;
            sat = 0; sq = 0; dot = 0;
            d[0] = longint'(it.attach_x) - anc[0];
            d[1] = longint'(it.attach_y) - anc[1];
            d[2] = longint'(it.attach_z) - anc[2];
            v[0] = longint'(it.vel_x);
            v[1] = longint'(it.vel_y);
            v[2] = longint'(it.vel_z);
            for (int i = 0; i < 3; i++) begin
                d[i] = clip32(d[i], sat);
                sq += mag(d[i]) * mag(d[i]);
            end
            len = root_floor(sq);
            for (int i = 0; i < 3; i++) begin
                // zero length leaves the unit vector at zero
                if (len == 0) u[i] = 0;
                else begin
                    q = (mag(d[i]) << FRAC_BITS) / len;
                    u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                end
                dot += mul_q(u[i], v[i]);
            end
            g = -(mul_q(stiff, longint'(len) - rest) + mul_q(damp, dot));
            for (int i = 0; i < 3; i++) f[i] = clip32(mul_q(g, u[i]), sat);
            if (len > 64'h7FFF_FFFF) begin
                len = 64'h7FFF_FFFF;
                sat = 1;
            end
            e.force_x = f[0][31:0];
            e.force_y = f[1][31:0];
            e.force_z = f[2][31:0];
            e.spring_length = len[PAR_W-1:0];
            e.saturated = sat;
            pending_q.push_back(e);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
                return;
            end
            e = pending_q.pop_front();
            if (got.force_x !== e.force_x || got.force_y !== e.force_y ||
                got.force_z !== e.force_z || got.spring_length !== e.spring_length ||
                got.saturated !== e.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp f=(%0d %0d %0d) len=%0d sat=%0b",
                              " got f=(%0d %0d %0d) len=%0d sat=%0b"},
                             e.force_x, e.force_y, e.force_z, e.spring_length, e.saturated,
                             got.force_x, got.force_y, got.force_z, got.spring_length,
                             got.saturated);
            end
        endfunction
    endclass

    logic                clk, rst_n;
    logic                in_valid, in_ready, out_valid, out_ready;
    in_item_t            in_data;
    out_item_t           out_data;
    logic                cfg_valid, cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [POS_W-1:0]    cfg_data;

    force_scoreboard sb;
    int  send_idle, recv_stall;
    bit  hold_req;
    int  cycles;

    linear_spring_damper_force u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        sb = new();
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && in_valid && in_ready) sb.note_input(in_data);
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_linear_spring_damper_force NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                for (int n = 0; n < HOLD_LEN; n++) @(negedge clk);
                hold_req = 0;
            end
            out_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [POS_W-1:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid = 0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (LAT_WAIT) @(negedge clk);
    endtask

    task automatic load_setting(logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
                                logic [POS_W-1:0] az, logic [POS_W-1:0] k,
                                logic [POS_W-1:0] c, logic [POS_W-1:0] r);
        wait_drain();
        write_reg(CFG_ANCHOR_X, ax);
        write_reg(CFG_ANCHOR_Y, ay);
        write_reg(CFG_ANCHOR_Z, az);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_REST_LEN, r);
        // out-of-range indexes must be ignored
        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    endtask

    function automatic in_item_t mk(int ax, int ay, int az, int vx, int vy, int vz);
        in_item_t it;
        it.attach_x = ax; it.attach_y = ay; it.attach_z = az;
        it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
        return it;
    endfunction

    function automatic in_item_t rand_item(int spread);
        in_item_t it;
        if ($urandom_range(3) == 0)
            it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            it = mk(int'(sb.anc[0] + $signed($urandom_range(2*spread)) - spread),
                    int'(sb.anc[1] + $signed($urandom_range(2*spread)) - spread),
                    int'(sb.anc[2] + $signed($urandom_range(2*spread)) - spread),
                    $signed($urandom_range(2*spread)) - spread,
                    $signed($urandom_range(2*spread)) - spread,
                    $signed($urandom_range(2*spread)) - spread);
        return it;
    endfunction

    initial
    begin
        in_valid = 0; in_data = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        send_idle = 0; recv_stall = 0; hold_req = 0;
        rst_n = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed items under reset values, then a typical setting
        send_item(mk(0, 0, 0, 0, 0, 0));
        send_item(mk(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0));
        load_setting(32'h0001_0000, 32'hFFFF_0000, 0, 32'h0002_0000, 32'h0000_8000,
                     32'h0001_0000);
        send_item(mk(32'h0001_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 1, -1));
        send_item(mk(32'h0004_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 0, 0));
        send_item(mk(32'h0001_0000, 32'h0002_0000, 0, 0, 32'h8000_0000, 0));
        send_item(mk(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 0, 0, 32'h7FFF_FFFF));
        send_item(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(mk(32'h0001_0001, 32'hFFFF_0000, 0, -5, 7, 9));
        // extreme anchors and parameters: clipped differences, long spring
        load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1));
        send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        send_item(mk(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_item(mk(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        send_item(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: load_setting(0, 0, 0, 0, 0, 0);
                1: load_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                2: load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
                default: load_setting($urandom_range(32'h0010_0000) - 32'h0008_0000,
                                      $urandom_range(32'h0010_0000) - 32'h0008_0000,
                                      $urandom_range(32'h0010_0000) - 32'h0008_0000,
                                      $urandom_range(32'h0040_0000),
                                      $urandom_range(32'h0004_0000),
                                      $urandom_range(32'h0008_0000));
            endcase
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            for (int n = 0; n < 200; n++)
            begin
                if (p == 3 && n == 20) hold_req = 1;
                // pause the sender until the pipeline has emptied
                if (p == 4 && n == 100) wait_drain();
                send_item(rand_item((n % 3 == 0) ? 32'h4000_0000 : 32'h0004_0000));
            end
        end

        in_valid = 0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (LAT_WAIT) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("tb_linear_spring_damper_force OK");
        else
            $display("tb_linear_spring_damper_force NOT OK");
        $finish;
    end
endmodule
